@@ hdl/ice_pkg.sv @@
// ice_pkg: shared types, codes and constants for the intcode executor
// no dependencies; used by ice_ctrl, ice_dp and the top level
package ice_pkg;

  // memory geometry
  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int PC_W      = ADDR_W + 1;

  // word kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_EXEC    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_HALTED   = 3'd1;
  localparam logic [2:0] ST_WAIT_IN  = 3'd2;
  localparam logic [2:0] ST_BAD_OP   = 3'd3;
  localparam logic [2:0] ST_BAD_ADDR = 3'd4;

  // opcodes
  localparam logic [3:0] OP_NOP = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_IN  = 4'd3;
  localparam logic [3:0] OP_OUT = 4'd4;
  localparam logic [3:0] OP_JT  = 4'd5;
  localparam logic [3:0] OP_JF  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_EQ  = 4'd8;
  localparam logic [3:0] OP_ARB = 4'd9;
  localparam logic [6:0] OP_HALT  = 7'd99;
  localparam logic [6:0] OP_KINDS = 7'd10;

  // operand modes
  localparam logic [3:0] MODE_POS = 4'd0;
  localparam logic [3:0] MODE_REL = 4'd2;

  // reciprocal of ten: q = (x * DIV10_MAGIC) >> DIV10_SHIFT for 32-bit x
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;
  localparam int          DIGITS      = 5;

  // memory read address source
  typedef enum logic [1:0] {
    RA_PC   = 2'd0,
    RA_OPND = 2'd1,
    RA_AD1  = 2'd2,
    RA_AD2  = 2'd3
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       clr_wr;
    logic       load_in;
    logic       wr_host;
    logic       restart;
    logic       set_halt;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       load_word;
    logic       digit_step;
    logic       resolve;
    logic       load_a;
    logic       alu;
    logic       wb;
    logic       set_res;
    logic [2:0] res_code;
    logic       load_out;
    logic [1:0] k;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       addr_ok;
    logic       halted;
    logic       pc_oob;
    logic       word_neg;
    logic       op_halt;
    logic       op_bad;
    logic [2:0] len;
    logic       idx_oob;
    logic       ad_oob;
    logic       clear_last;
  } sts_t;

  // instruction length in words
  function automatic logic [2:0] inst_len(input logic [3:0] op);
    logic [2:0] n;
    n = 3'd1;
    case (op)
      OP_ADD, OP_MUL, OP_LT, OP_EQ: n = 3'd4;
      OP_IN, OP_OUT, OP_ARB:        n = 3'd2;
      OP_JT, OP_JF:                 n = 3'd3;
      default:                      n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

@@ hdl/ice_dp.sv @@
// ice_dp: datapath of the intcode executor: memory, pc, relative base,
// digit splitter, operand resolution, alu and result registers; uses ice_pkg
module ice_dp (
  input  logic                clk,
  input  logic                rst,
  input  ice_pkg::cmd_t       cmd,
  output ice_pkg::sts_t       sts,
  input  logic [1:0]          kind,
  input  logic [11:0]         address,
  input  logic signed [31:0]  value,
  input  logic                input_valid,
  output logic [2:0]          status,
  output logic                output_valid,
  output logic signed [31:0]  output_value,
  output logic                input_taken
);

  // latched input word
  logic [1:0]  kind_r;
  logic [11:0] addr_r;
  logic [31:0] val_r;
  logic        inv_r;

  // architectural state
  logic [ice_pkg::PC_W-1:0] pc;
  logic [31:0]              rb;
  logic                     halted;

  // memory
  logic [31:0]                mem [ice_pkg::MEM_WORDS];
  logic [31:0]                rdata;
  logic [ice_pkg::ADDR_W-1:0] raddr;
  logic [ice_pkg::ADDR_W-1:0] waddr;
  logic [31:0]                wdata;
  logic                       we;
  logic [ice_pkg::ADDR_W-1:0] clr_cnt;

  // decode and operands
  logic [31:0]                dig_cur;
  logic [3:0]                 dig [ice_pkg::DIGITS];
  logic [63:0]                prod;
  logic [28:0]                quo;
  logic [31:0]                quo10;
  logic [3:0]                 rem;
  logic [6:0]                 op7;
  logic [3:0]                 op;
  logic [2:0]                 len;
  logic [ice_pkg::PC_W-1:0]   idx;
  logic [3:0]                 mode;
  logic [31:0]                opnd_addr;
  logic [ice_pkg::ADDR_W-1:0] ad1, ad2, ad3;
  logic [31:0]                a_r, b_r, res;
  logic                       wb_wr;
  logic                       jump_cond;

  // pending result
  logic [2:0]  pend_status;
  logic        pend_ov;
  logic [31:0] pend_val;
  logic        pend_it;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= kind;
      addr_r <= address;
      val_r  <= value;
      inv_r  <= input_valid;
    end
  end

  // digit splitter, one decimal digit a step, low digit first
  assign prod  = 64'(dig_cur) * 64'(ice_pkg::DIV10_MAGIC);
  assign quo   = prod[63:ice_pkg::DIV10_SHIFT];
  assign quo10 = {quo[28:0], 3'b000} + {2'b00, quo, 1'b0};
  assign rem   = 4'(dig_cur - quo10);

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      dig_cur <= rdata;
    end else if (cmd.digit_step) begin
      dig_cur <= 32'(quo);
      for (int i = 0; i < ice_pkg::DIGITS - 1; i++) begin
        dig[i] <= dig[i+1];
      end
      dig[ice_pkg::DIGITS-1] <= rem;
    end
  end

  assign op7 = 7'({dig[1], 3'b000}) + 7'({dig[1], 1'b0}) + 7'(dig[0]);
  assign op  = op7[3:0];
  assign len = ice_pkg::inst_len(op);

  // operand address
  assign idx = pc + ice_pkg::PC_W'(cmd.k);

  always_comb begin
    unique case (cmd.k)
      2'd1:    mode = dig[2];
      2'd2:    mode = dig[3];
      default: mode = dig[4];
    endcase
  end

  always_comb begin
    if (mode == ice_pkg::MODE_POS) begin
      opnd_addr = rdata;
    end else if (mode == ice_pkg::MODE_REL) begin
      opnd_addr = rdata + rb;
    end else begin
      opnd_addr = 32'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      unique case (cmd.k)
        2'd1:    ad1 <= opnd_addr[ice_pkg::ADDR_W-1:0];
        2'd2:    ad2 <= opnd_addr[ice_pkg::ADDR_W-1:0];
        default: ad3 <= opnd_addr[ice_pkg::ADDR_W-1:0];
      endcase
    end
  end

  // alu, registered
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_r <= rdata;
    end
    if (cmd.alu) begin
      b_r <= rdata;
      case (op)
        ice_pkg::OP_ADD: res <= a_r + rdata;
        ice_pkg::OP_MUL: res <= 32'(a_r * rdata);
        ice_pkg::OP_LT:  res <= {31'd0, $signed(a_r) < $signed(rdata)};
        ice_pkg::OP_EQ:  res <= {31'd0, a_r == rdata};
        default:         res <= a_r;
      endcase
    end
  end

  assign jump_cond = (op == ice_pkg::OP_JT) ? (a_r != 32'd0) : (a_r == 32'd0);
  assign wb_wr = cmd.wb && (op == ice_pkg::OP_ADD || op == ice_pkg::OP_MUL ||
                            op == ice_pkg::OP_LT || op == ice_pkg::OP_EQ ||
                            (op == ice_pkg::OP_IN && inv_r));

  // memory write source
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = 32'd0;
    priority if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.wr_host) begin
      we    = 1'b1;
      waddr = ice_pkg::ADDR_W'(addr_r);
      wdata = val_r;
    end else if (wb_wr) begin
      we    = 1'b1;
      waddr = (op == ice_pkg::OP_IN) ? ad1 : ad3;
      wdata = (op == ice_pkg::OP_IN) ? val_r : res;
    end
  end

  // memory read source
  always_comb begin
    unique case (cmd.rd_sel)
      ice_pkg::RA_PC:   raddr = pc[ice_pkg::ADDR_W-1:0];
      ice_pkg::RA_OPND: raddr = idx[ice_pkg::ADDR_W-1:0];
      ice_pkg::RA_AD1:  raddr = ad1;
      default:          raddr = ad2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // pc, relative base, halt flag
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      pc     <= '0;
      rb     <= '0;
      halted <= 1'b0;
    end else begin
      if (cmd.set_halt) begin
        halted <= 1'b1;
      end
      if (cmd.wb) begin
        case (op)
          ice_pkg::OP_IN: begin
            if (inv_r) begin
              pc <= pc + ice_pkg::PC_W'(len);
            end
          end
          ice_pkg::OP_JT, ice_pkg::OP_JF: begin
            if (!jump_cond) begin
              pc <= pc + ice_pkg::PC_W'(len);
            end else if (b_r < 32'(ice_pkg::MEM_WORDS)) begin
              pc <= ice_pkg::PC_W'(b_r[ice_pkg::ADDR_W-1:0]);
            end
          end
          ice_pkg::OP_ARB: begin
            rb <= rb + a_r;
            pc <= pc + ice_pkg::PC_W'(len);
          end
          default: pc <= pc + ice_pkg::PC_W'(len);
        endcase
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      pend_status <= cmd.res_code;
      pend_ov     <= 1'b0;
      pend_val    <= 32'd0;
      pend_it     <= 1'b0;
    end else if (cmd.wb) begin
      pend_status <= ice_pkg::ST_DONE;
      pend_ov     <= 1'b0;
      pend_val    <= 32'd0;
      pend_it     <= 1'b0;
      case (op)
        ice_pkg::OP_IN: begin
          if (inv_r) begin
            pend_it <= 1'b1;
          end else begin
            pend_status <= ice_pkg::ST_WAIT_IN;
          end
        end
        ice_pkg::OP_OUT: begin
          pend_ov  <= 1'b1;
          pend_val <= a_r;
        end
        ice_pkg::OP_JT, ice_pkg::OP_JF: begin
          if (jump_cond && b_r >= 32'(ice_pkg::MEM_WORDS)) begin
            pend_status <= ice_pkg::ST_BAD_ADDR;
          end
        end
        default: pend_status <= ice_pkg::ST_DONE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= pend_status;
      output_valid <= pend_ov;
      output_value <= pend_val;
      input_taken  <= pend_it;
    end
  end

  // status to controller
  always_comb begin
    sts.kind       = kind_r;
    sts.addr_ok    = 32'(addr_r) < 32'(ice_pkg::MEM_WORDS);
    sts.halted     = halted;
    sts.pc_oob     = 32'(pc) >= 32'(ice_pkg::MEM_WORDS);
    sts.word_neg   = rdata[31];
    sts.op_halt    = op7 == ice_pkg::OP_HALT;
    sts.op_bad     = op7 >= ice_pkg::OP_KINDS && op7 != ice_pkg::OP_HALT;
    sts.len        = len;
    sts.idx_oob    = 32'(idx) >= 32'(ice_pkg::MEM_WORDS);
    sts.ad_oob     = opnd_addr >= 32'(ice_pkg::MEM_WORDS);
    sts.clear_last = clr_cnt == ice_pkg::ADDR_W'(ice_pkg::MEM_WORDS - 1);
  end

endmodule

@@ hdl/ice_ctrl.sv @@
// ice_ctrl: sequencer of the intcode executor and both handshakes
// uses ice_pkg; drives ice_dp through cmd_t and reads sts_t
module ice_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ice_pkg::cmd_t cmd,
  input  ice_pkg::sts_t sts
);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_ACT    = 14'b00000000000100,
    S_FETCH  = 14'b00000000001000,
    S_WORD   = 14'b00000000010000,
    S_DIGIT  = 14'b00000000100000,
    S_DECODE = 14'b00000001000000,
    S_OPRD   = 14'b00000010000000,
    S_OPRES  = 14'b00000100000000,
    S_RDA    = 14'b00001000000000,
    S_RDB    = 14'b00010000000000,
    S_ALU    = 14'b00100000000000,
    S_WB     = 14'b01000000000000,
    S_RESP   = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] k, k_next;
  logic [2:0] cnt, cnt_next;
  logic       out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      k     <= 2'd1;
      cnt   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      cnt   <= cnt_next;
    end
  end

  // result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    k_next     = k;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.rd_sel = ice_pkg::RA_PC;
    cmd.k      = k;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_ACT;
        end
      end
      S_ACT: begin
        cmd.set_res  = 1'b1;
        cmd.res_code = ice_pkg::ST_DONE;
        state_next   = S_RESP;
        case (sts.kind)
          ice_pkg::KIND_WRITE: begin
            if (sts.addr_ok) begin
              cmd.wr_host = 1'b1;
            end else begin
              cmd.res_code = ice_pkg::ST_BAD_ADDR;
            end
          end
          ice_pkg::KIND_RESTART: cmd.restart = 1'b1;
          ice_pkg::KIND_EXEC: begin
            if (sts.halted) begin
              cmd.res_code = ice_pkg::ST_HALTED;
            end else if (sts.pc_oob) begin
              cmd.res_code = ice_pkg::ST_BAD_ADDR;
            end else begin
              cmd.set_res = 1'b0;
              state_next  = S_FETCH;
            end
          end
          default: cmd.res_code = ice_pkg::ST_DONE;
        endcase
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ice_pkg::RA_PC;
        state_next = S_WORD;
      end
      S_WORD: begin
        if (sts.word_neg) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ice_pkg::ST_BAD_OP;
          state_next   = S_RESP;
        end else begin
          cmd.load_word = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.digit_step = 1'b1;
        cnt_next       = cnt + 1'b1;
        if (cnt == 3'(ice_pkg::DIGITS - 1)) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        k_next = 2'd1;
        priority if (sts.op_halt) begin
          cmd.set_halt = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = ice_pkg::ST_HALTED;
          state_next   = S_RESP;
        end else if (sts.op_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ice_pkg::ST_BAD_OP;
          state_next   = S_RESP;
        end else if (sts.len == 3'd1) begin
          state_next = S_WB;
        end else begin
          state_next = S_OPRD;
        end
      end
      S_OPRD: begin
        if (sts.idx_oob) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ice_pkg::ST_BAD_ADDR;
          state_next   = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ice_pkg::RA_OPND;
          state_next = S_OPRES;
        end
      end
      S_OPRES: begin
        if (sts.ad_oob) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ice_pkg::ST_BAD_ADDR;
          state_next   = S_RESP;
        end else begin
          cmd.resolve = 1'b1;
          if (3'(k) + 3'd1 == sts.len) begin
            state_next = S_RDA;
          end else begin
            k_next     = k + 2'd1;
            state_next = S_OPRD;
          end
        end
      end
      S_RDA: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ice_pkg::RA_AD1;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ice_pkg::RA_AD2;
        cmd.load_a = 1'b1;
        state_next = S_ALU;
      end
      S_ALU: begin
        cmd.alu    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  // an accepted word always goes to dispatch next
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_ACT)
    else $error("accepted word did not reach dispatch");

  // writeback comes only after the alu or a one-word instruction
  a_wb_order: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> $past(state) == S_ALU || $past(state) == S_DECODE)
    else $error("writeback without alu or decode");

  // a result load always shows a valid result next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  // operand index stays in 1..3
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    state == S_OPRES |-> k != 2'd0)
    else $error("operand index out of range");
`endif

endmodule

@@ hdl/intcode_instruction_executor_unit.sv @@
// intcode_instruction_executor_unit: top level of the intcode core
// depends on ice_pkg, ice_ctrl and ice_dp
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | kind, address, value, input_valid
//  out     | out_valid / out_ready| status, output_valid, output_value, input_taken
//
// an execute word runs the digit splitter over DIGITS digits plus one
// registered read per fetch, operand word and operand value on the single
// memory read port
// after reset a clearing pass zeroes all MEM_WORDS (4096) memory words with
// in_ready low
// one word is in flight at a time; a waiting result holds the sequencer in
// its last state until out_ready
module intcode_instruction_executor_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [11:0]        address,
  input  logic signed [31:0] value,
  input  logic               input_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic               output_valid,
  output logic signed [31:0] output_value,
  output logic               input_taken
);

  ice_pkg::cmd_t cmd;
  ice_pkg::sts_t sts;

  // sequencer
  ice_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  ice_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .address      (address),
    .value        (value),
    .input_valid  (input_valid),
    .status       (status),
    .output_valid (output_valid),
    .output_value (output_value),
    .input_taken  (input_taken)
  );

endmodule

@@ verif/intcode_instruction_executor_unit_tb.sv @@
// intcode_instruction_executor_unit_tb: self-checking bench for the intcode core
// depends on ice_pkg and intcode_instruction_executor_unit; predicts each result word
`timescale 1ns / 1ps

module intcode_instruction_executor_unit_tb;

  typedef struct packed {
    logic [2:0]  status;
    logic        ov;
    logic [31:0] oval;
    logic        taken;
  } result_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int ITEMS      = 1900;
  localparam int PRED_DEPTH = 16;

  // kind code with no action
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         kind = ice_pkg::KIND_WRITE;
  logic [11:0]        address = '0;
  logic signed [31:0] value = '0;
  logic               input_valid = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic               output_valid;
  logic signed [31:0] output_value;
  logic               input_taken;

  // shadow copy of the core state
  logic [31:0] mem_shadow [ice_pkg::MEM_WORDS];
  int unsigned pc_shadow;
  logic [31:0] rbase_shadow;
  bit          halted_shadow;

  // predicted result words in order of acceptance
  result_t     pred_fifo [PRED_DEPTH];
  int unsigned pred_wr = 0;
  int unsigned pred_rd = 0;

  int          mismatches = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;

  intcode_instruction_executor_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .address(address), .value(value), .input_valid(input_valid),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .output_valid(output_valid),
    .output_value(output_value), .input_taken(input_taken)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // words per instruction, indexed by opcode
  function automatic int unsigned instr_words(int unsigned op);
    case (op)
      ice_pkg::OP_ADD, ice_pkg::OP_MUL, ice_pkg::OP_LT, ice_pkg::OP_EQ: return 4;
      ice_pkg::OP_IN, ice_pkg::OP_OUT, ice_pkg::OP_ARB:                 return 2;
      ice_pkg::OP_JT, ice_pkg::OP_JF:                                   return 3;
      default:                                                          return 1;
    endcase
  endfunction

  // one instruction on the shadow state
  function automatic result_t intcode_exec_predict(logic [31:0] inval, bit offered);
    result_t     r;
    logic [31:0] word;
    int unsigned op, len, idx, mode, divv;
    longint      a;
    int unsigned ad [4];
    logic [31:0] va, vb;
    longint      target;
    bit          cond;
    r = '0;
    ad = '{0, 0, 0, 0};
    if (halted_shadow) begin
      r.status = ice_pkg::ST_HALTED;
      return r;
    end
    if (pc_shadow >= ice_pkg::MEM_WORDS) begin
      r.status = ice_pkg::ST_BAD_ADDR;
      return r;
    end
    word = mem_shadow[pc_shadow];
    if (word[31]) begin
      r.status = ice_pkg::ST_BAD_OP;
      return r;
    end
    op = word % 100;
    if (op == ice_pkg::OP_HALT) begin
      halted_shadow = 1'b1;
      r.status = ice_pkg::ST_HALTED;
      return r;
    end
    if (op >= ice_pkg::OP_KINDS) begin
      r.status = ice_pkg::ST_BAD_OP;
      return r;
    end
    len = instr_words(op);
    // resolve operand addresses
    for (int k = 1; k < len; k++) begin
      idx = pc_shadow + k;
      if (idx >= ice_pkg::MEM_WORDS) begin
        r.status = ice_pkg::ST_BAD_ADDR;
        return r;
      end
      divv = (k == 1) ? 100 : (k == 2) ? 1000 : 10000;
      mode = (word / divv) % 10;
      if (mode == ice_pkg::MODE_POS) a = longint'($signed(mem_shadow[idx]));
      else if (mode == ice_pkg::MODE_REL)
        a = longint'($signed(mem_shadow[idx] + rbase_shadow));
      else a = idx;
      if (a < 0 || a >= ice_pkg::MEM_WORDS) begin
        r.status = ice_pkg::ST_BAD_ADDR;
        return r;
      end
      ad[k] = 32'(a);
    end
    va = mem_shadow[ad[1]];
    vb = mem_shadow[ad[2]];
    case (op)
      ice_pkg::OP_ADD: mem_shadow[ad[3]] = va + vb;
      ice_pkg::OP_MUL: mem_shadow[ad[3]] = va * vb;
      ice_pkg::OP_IN: begin
        if (!offered) begin
          r.status = ice_pkg::ST_WAIT_IN;
          return r;
        end
        mem_shadow[ad[1]] = inval;
        r.taken = 1'b1;
      end
      ice_pkg::OP_OUT: begin
        r.ov = 1'b1;
        r.oval = va;
      end
      ice_pkg::OP_JT, ice_pkg::OP_JF: begin
        cond = (op == ice_pkg::OP_JT) ? (va != 0) : (va == 0);
        if (cond) begin
          target = longint'($signed(vb));
          if (target < 0 || target >= ice_pkg::MEM_WORDS) begin
            r.status = ice_pkg::ST_BAD_ADDR;
            return r;
          end
          pc_shadow = 32'(target);
          return r;
        end
      end
      ice_pkg::OP_LT: mem_shadow[ad[3]] = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
      ice_pkg::OP_EQ: mem_shadow[ad[3]] = (va == vb) ? 32'd1 : 32'd0;
      ice_pkg::OP_ARB: rbase_shadow = rbase_shadow + va;
      default: ;
    endcase
    pc_shadow = pc_shadow + len;
    return r;
  endfunction

  // one accepted word on the shadow state
  function automatic result_t intcode_step_predict(logic [1:0] k, logic [11:0] ad,
                                                   logic [31:0] v, bit iv);
    result_t r;
    r = '0;
    case (k)
      ice_pkg::KIND_WRITE: mem_shadow[ad] = v;
      ice_pkg::KIND_EXEC: r = intcode_exec_predict(v, iv);
      ice_pkg::KIND_RESTART: begin
        pc_shadow = 0;
        rbase_shadow = '0;
        halted_shadow = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // drive one word and wait for its acceptance, then maybe pause the burst
  task automatic send_word(logic [1:0] k, logic [11:0] ad, logic [31:0] v, bit iv);
    int gap;
    @(negedge clk);
    kind <= k;
    address <= ad;
    value <= v;
    input_valid <= iv;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred_fifo[pred_wr % PRED_DEPTH] = intcode_step_predict(k, ad, v, iv);
    pred_wr++;
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic poke(int ad, logic [31:0] v);
    send_word(ice_pkg::KIND_WRITE, ad[11:0], v, 1'b0);
  endtask

  task automatic step_exec(logic [31:0] v, bit iv);
    send_word(ice_pkg::KIND_EXEC, '0, v, iv);
  endtask

  // every opcode but OP_NOP and OP_JF, modes, input wait, a jump, halt, restart and the unused kind
  task automatic test_directed_ops();
    int prog [$];
    prog = '{1101, 7, 5, 30, 1002, 30, 3, 31, 3, 32, 4, 32, 109, 5, 204, 27,
             1107, -1, 1, 33, 1108, 4, 4, 34, 1105, 1, 28, 0, 99};
    foreach (prog[i]) poke(i, prog[i]);
    step_exec(32'd0, 1'b0);
    step_exec(32'd0, 1'b0);
    step_exec(32'h1234_5678, 1'b0);
    step_exec(32'h8000_0000, 1'b1);
    repeat (8) step_exec($urandom, 1'($urandom_range(0, 1)));
    send_word(KIND_UNUSED, 12'hfff, 32'hffff_ffff, 1'b1);
    send_word(ice_pkg::KIND_RESTART, 12'hfff, 32'h7fff_ffff, 1'b1);
  endtask

  // bad opcodes, negative words, bad addresses, jump out of range, top address
  task automatic test_special_cases();
    poke(4095, 32'h7fff_ffff);
    poke(0, 32'h8000_0000);
    step_exec('0, 1'b0);
    poke(0, 32'd57);
    step_exec('0, 1'b0);
    poke(0, 32'd1);
    poke(1, 32'hffff_ffff);
    step_exec('0, 1'b0);
    poke(0, 32'd1105);
    poke(1, 32'd1);
    poke(2, 32'd5000);
    step_exec('0, 1'b0);
    poke(0, 32'd203);
    poke(1, 32'd9000);
    step_exec('0, 1'b0);
    send_word(ice_pkg::KIND_RESTART, '0, '0, 1'b0);
  endtask

  function automatic logic [31:0] rand_operand();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 40);
    if ($urandom_range(0, 1)) return $urandom;
    return $urandom_range(4080, 4095);
  endfunction

  function automatic logic [31:0] rand_instr();
    int unsigned op, m1, m2, m3;
    case ($urandom_range(0, 15))
      12: op = ice_pkg::OP_HALT;
      13: op = $urandom_range(10, 98);
      14: return $urandom;
      default: op = $urandom_range(0, 9);
    endcase
    m1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 2);
    m2 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 2);
    m3 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 2);
    return op + 100 * m1 + 1000 * m2 + 10000 * m3;
  endfunction

  // load a short random program, restart, then run it with random input offers, stray writes and unused kinds
  task automatic run_random_program();
    int n, runs;
    n = $urandom_range(8, 24);
    for (int a = 0; a < n; a++) begin
      if ($urandom_range(0, 2) == 0) poke(a, rand_instr());
      else poke(a, rand_operand());
    end
    send_word(ice_pkg::KIND_RESTART, 12'($urandom), $urandom,
              1'($urandom_range(0, 1)));
    runs = $urandom_range(5, 30);
    repeat (runs) begin
      case ($urandom_range(0, 19))
        0: poke($urandom, $urandom);
        1: poke($urandom_range(0, 40), rand_operand());
        2: send_word(KIND_UNUSED, 12'($urandom), $urandom, 1'($urandom_range(0, 1)));
        default: step_exec($urandom, 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  task automatic test_random_programs();
    while (words_sent < ITEMS / 2) run_random_program();
  endtask

  // receiver backs off for a long stretch while programs keep streaming
  task automatic test_backpressure();
    hold_req = 1'b1;
    while (words_sent < ITEMS) run_random_program();
  endtask

  // receiver stall pattern with a long hold-off on request
  initial begin : receiver_stall
    int hold_cnt;
    int phase;
    bit hold_done;
    hold_cnt = 0;
    phase = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      phase = (phase + 1) % 120;
      if (hold_req && !hold_done) begin
        hold_cnt = 600;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (phase < 40) begin
        out_ready <= 1'b1;
      end else if (phase < 80) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pred_wr == pred_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word status=%0d", status);
      end else begin
        want = pred_fifo[pred_rd % PRED_DEPTH];
        pred_rd++;
        if (status !== want.status || output_valid !== want.ov ||
            output_value !== want.oval || input_taken !== want.taken) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d ov=%0d val=%h tk=%0d got st=%0d ov=%0d val=%h tk=%0d",
                     want.status, want.ov, want.oval, want.taken,
                     status, output_valid, output_value, input_taken);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("intcode_instruction_executor_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    foreach (mem_shadow[i]) mem_shadow[i] = '0;
    pc_shadow = 0;
    rbase_shadow = '0;
    halted_shadow = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_special_cases();
    test_random_programs();
    test_backpressure();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pred_wr != pred_rd) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pred_wr == pred_rd) begin
      $display("intcode_instruction_executor_unit_tb: PASS");
    end else begin
      $display("intcode_instruction_executor_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ice_pkg.sv
hdl/ice_dp.sv
hdl/ice_ctrl.sv
hdl/intcode_instruction_executor_unit.sv
verif/intcode_instruction_executor_unit_tb.sv
